[sv/sensor_frame_parser_level_monitor_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame parser level monitor
// Shorthand for clocked implication checks with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_PARSER_LEVEL_MONITOR_CORE_MACROS_SVH
`define SENSOR_FRAME_PARSER_LEVEL_MONITOR_CORE_MACROS_SVH

// Same-cycle implication.
`define SFPLM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfplm assertion failed");

// Next-cycle implication.
`define SFPLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfplm assertion failed");

`endif

[sv/sfplm_pkg.sv]
// ----------------------------------------------------------------------------
// sfplm_pkg
// Types and constants shared by the frame parser and level monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfplm_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] EV_GOOD       = 2'd0;
  localparam logic [1:0] EV_CHECKSUM   = 2'd1;
  localparam logic [1:0] EV_NO_SIGNAL  = 2'd2;
  localparam logic [1:0] EV_BAD_PACKET = 2'd3;

  localparam logic [2:0] REG_START_MARKER   = 3'd0;
  localparam logic [2:0] REG_ACCEPTED_TYPE  = 3'd1;
  localparam logic [2:0] REG_TANK_DEPTH     = 3'd2;
  localparam logic [2:0] REG_BYTE_GAP_LIMIT = 3'd3;
  localparam logic [2:0] REG_SILENCE_LIMIT  = 3'd4;

  localparam logic [15:0] GAP_MAX     = 16'hFFFF;
  localparam logic [19:0] SILENCE_MAX = 20'hFFFFF;
  localparam logic [6:0]  PERCENT_SCALE = 7'd100;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  accepted_type;
    logic [15:0] vessel_depth;
    logic [15:0] byte_gap_limit;
    logic [19:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] reading;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

[sv/sfplm_in_if.sv]
// ----------------------------------------------------------------------------
// sfplm_in_if
// Request channel carrying received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfplm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

[sv/sfplm_out_if.sv]
// ----------------------------------------------------------------------------
// sfplm_out_if
// Result channel carrying readings, checksum errors and alarms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfplm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] echo_range;
  logic [15:0] fill_height;
  logic [6:0]  level_percent;

  modport source (output valid, output event_kind, output echo_range,
                  output fill_height, output level_percent, input ready);
  modport sink (input valid, input event_kind, input echo_range,
                input fill_height, input level_percent, output ready);
endinterface

[sv/sfplm_front.sv]
// ----------------------------------------------------------------------------
// sfplm_front
// Frame parser and silence timer; classifies each request and emits commands for frames and alarms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfplm_front (
  input  logic               clk,
  input  logic               rst,
  input  sfplm_pkg::cfg_t    cfg,
  sfplm_in_if.sink           rx_chan,
  output logic               cmd_valid,
  output sfplm_pkg::cmd_t    cmd,
  input  logic               cmd_ready
);

  logic [7:0]  frame_bytes [4];
  logic [2:0]  pos, pos_next;
  logic [15:0] gap, gap_next, gap_inc;
  logic [19:0] silence, silence_next, silence_inc;
  logic        ck_err, ck_err_next;
  logic        alarm, alarm_next;
  logic        fb_we;
  logic        accept;
  logic [7:0]  sum;

  assign rx_chan.ready = cmd_ready;
  assign accept = rx_chan.valid && cmd_ready;

  assign gap_inc = (gap == sfplm_pkg::GAP_MAX) ? gap : gap + 16'd1;
  assign silence_inc = (silence == sfplm_pkg::SILENCE_MAX) ? silence : silence + 20'd1;
  assign sum = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];

  always_comb begin
    pos_next     = pos;
    gap_next     = gap;
    silence_next = silence;
    ck_err_next  = ck_err;
    alarm_next   = alarm;
    fb_we        = 1'b0;
    cmd_valid    = 1'b0;
    cmd.kind     = sfplm_pkg::EV_GOOD;
    cmd.reading  = {frame_bytes[2], frame_bytes[3]};
    if (accept) begin
      if (rx_chan.opcode == sfplm_pkg::OP_TICK) begin
        gap_next     = gap_inc;
        silence_next = silence_inc;
        if (pos != 3'd0 && gap_inc > cfg.byte_gap_limit) begin
          pos_next = 3'd0;
        end
        if (silence_inc > cfg.silence_limit && !alarm) begin
          alarm_next = 1'b1;
          cmd_valid  = 1'b1;
          cmd.kind   = ck_err ? sfplm_pkg::EV_BAD_PACKET : sfplm_pkg::EV_NO_SIGNAL;
        end
      end else begin
        gap_next = 16'd0;
        if (pos == 3'd0 && rx_chan.rx_byte != cfg.start_marker) begin
          pos_next = 3'd0;
        end else if (pos < 3'd4) begin
          fb_we    = 1'b1;
          pos_next = pos + 3'd1;
        end else begin
          pos_next = 3'd0;
          if (frame_bytes[1] == cfg.accepted_type) begin
            cmd_valid = 1'b1;
            if (sum != rx_chan.rx_byte) begin
              ck_err_next = 1'b1;
              cmd.kind    = sfplm_pkg::EV_CHECKSUM;
            end else begin
              silence_next = 20'd0;
              ck_err_next  = 1'b0;
              alarm_next   = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      frame_bytes[pos[1:0]] <= rx_chan.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 3'd0;
      gap     <= 16'd0;
      silence <= 20'd0;
      ck_err  <= 1'b0;
      alarm   <= 1'b0;
    end else begin
      pos     <= pos_next;
      gap     <= gap_next;
      silence <= silence_next;
      ck_err  <= ck_err_next;
      alarm   <= alarm_next;
    end
  end

endmodule

[sv/sfplm_queue.sv]
// ----------------------------------------------------------------------------
// sfplm_queue
// Short command queue between the parser and the level calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfplm_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  sfplm_pkg::cmd_t push_data,
  output logic            push_ready,
  output logic            pop_valid,
  output sfplm_pkg::cmd_t pop_data,
  input  logic            pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfplm_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[sv/sfplm_back.sv]
// ----------------------------------------------------------------------------
// sfplm_back
// Level calculator: fill level, iterative percentage division, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfplm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     vessel_depth,
  input  logic            cmd_valid,
  input  sfplm_pkg::cmd_t cmd,
  output logic            cmd_pop,
  sfplm_out_if.source     event_chan
);

  sfplm_pkg::back_state_t st, st_next;

  logic [15:0] dist_r, level_r;
  logic [22:0] num;
  logic [6:0]  quo;
  logic [2:0]  bit_idx;
  logic [22:0] den_shift;
  logic        out_free;
  logic        load_good, load_other, start_good;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_dist, out_level;
  logic [6:0]  out_pct;

  assign out_free  = !out_valid || event_chan.ready;
  assign den_shift = 23'(vessel_depth) << bit_idx;

  always_comb begin
    st_next    = st;
    cmd_pop    = 1'b0;
    start_good = 1'b0;
    load_good  = 1'b0;
    load_other = 1'b0;
    case (st)
      sfplm_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == sfplm_pkg::EV_GOOD) begin
            cmd_pop    = 1'b1;
            start_good = 1'b1;
            st_next    = sfplm_pkg::BK_MUL;
          end else if (out_free) begin
            cmd_pop    = 1'b1;
            load_other = 1'b1;
          end
        end
      end
      sfplm_pkg::BK_MUL: begin
        st_next = sfplm_pkg::BK_DIV;
      end
      sfplm_pkg::BK_DIV: begin
        if (bit_idx == 3'd0) begin
          st_next = sfplm_pkg::BK_DONE;
        end
      end
      sfplm_pkg::BK_DONE: begin
        if (out_free) begin
          load_good = 1'b1;
          st_next   = sfplm_pkg::BK_IDLE;
        end
      end
      default: begin
        st_next = sfplm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sfplm_pkg::BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start_good) begin
      dist_r  <= cmd.reading;
      level_r <= (cmd.reading < vessel_depth) ? vessel_depth - cmd.reading : 16'd0;
    end
    if (st == sfplm_pkg::BK_MUL) begin
      num     <= 23'(level_r * sfplm_pkg::PERCENT_SCALE);
      quo     <= 7'd0;
      bit_idx <= 3'd6;
    end
    if (st == sfplm_pkg::BK_DIV) begin
      if (num >= den_shift) begin
        num          <= num - den_shift;
        quo[bit_idx] <= 1'b1;
      end
      bit_idx <= bit_idx - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_good) begin
      out_kind  <= sfplm_pkg::EV_GOOD;
      out_dist  <= dist_r;
      out_level <= level_r;
      out_pct   <= (vessel_depth == 16'd0) ? 7'd0 : quo;
    end else if (load_other) begin
      out_kind  <= cmd.kind;
      out_dist  <= 16'd0;
      out_level <= 16'd0;
      out_pct   <= 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_good || load_other) begin
      out_valid <= 1'b1;
    end else if (event_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign event_chan.valid         = out_valid;
  assign event_chan.event_kind    = out_kind;
  assign event_chan.echo_range    = out_dist;
  assign event_chan.fill_height   = out_level;
  assign event_chan.level_percent = out_pct;

endmodule

[sv/sensor_frame_parser_level_monitor_core.sv]
// ----------------------------------------------------------------------------
// sensor_frame_parser_level_monitor_core
// Start-byte framed distance packet parser with tank level and silence alarm.
// ----------------------------------------------------------------------------
//  Channel     Direction  Carries
//  rx_chan     in         opcode (byte or tick), rx_byte
//  event_chan  out        event_kind, echo_range, fill_height, level_percent
//  cfg port    in         cfg_we, cfg_index, cfg_data (register write)
//
//  The parser takes one request per cycle while the command queue has room.
//  A good reading passes through the level calculator's MUL state, the
//  multiply by 100, and DIV state, the one-bit-a-step percentage division.
//  Errors and alarms go from idle straight to the output register once free.
//  Reset is synchronous and clears all control state; no clearing pass.
//  A stalled result holds in the output register while parsing goes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_frame_parser_level_monitor_core_macros.svh"

module sensor_frame_parser_level_monitor_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  sfplm_in_if.sink    rx_chan,
  sfplm_out_if.source event_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  sfplm_pkg::cfg_t cfg;
  sfplm_pkg::cmd_t push_cmd, pop_cmd;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker   <= 8'd170;
      cfg.accepted_type  <= 8'd1;
      cfg.vessel_depth   <= 16'd2000;
      cfg.byte_gap_limit <= 16'd1000;
      cfg.silence_limit  <= 20'd30000;
    end else if (cfg_we) begin
      case (cfg_index)
        sfplm_pkg::REG_START_MARKER:   cfg.start_marker   <= cfg_data[7:0];
        sfplm_pkg::REG_ACCEPTED_TYPE:  cfg.accepted_type  <= cfg_data[7:0];
        sfplm_pkg::REG_TANK_DEPTH:     cfg.vessel_depth   <= cfg_data[15:0];
        sfplm_pkg::REG_BYTE_GAP_LIMIT: cfg.byte_gap_limit <= cfg_data[15:0];
        sfplm_pkg::REG_SILENCE_LIMIT:  cfg.silence_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfplm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rx_chan   (rx_chan),
    .cmd_valid (push_valid),
    .cmd       (push_cmd),
    .cmd_ready (push_ready)
  );

  sfplm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_cmd),
    .pop_ready  (pop_ready)
  );

  sfplm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .vessel_depth (cfg.vessel_depth),
    .cmd_valid    (pop_valid),
    .cmd          (pop_cmd),
    .cmd_pop      (pop_ready),
    .event_chan   (event_chan)
  );

  `SFPLM_ASSERT_NOW(a_other_fields_zero, clk, rst,
    event_chan.valid && event_chan.event_kind != sfplm_pkg::EV_GOOD,
    event_chan.echo_range == 16'd0 && event_chan.fill_height == 16'd0 &&
    event_chan.level_percent == 7'd0)
  `SFPLM_ASSERT_NOW(a_percent_range, clk, rst,
    event_chan.valid, event_chan.level_percent <= 7'd100)
  `SFPLM_ASSERT_NOW(a_level_sum, clk, rst,
    event_chan.valid && event_chan.event_kind == sfplm_pkg::EV_GOOD &&
    event_chan.echo_range < cfg.vessel_depth,
    17'(event_chan.fill_height) + 17'(event_chan.echo_range) == 17'(cfg.vessel_depth))

endmodule

[bench/tb_sensor_frame_parser_level_monitor_core.sv]
// ----------------------------------------------------------------------------
// tb_sensor_frame_parser_level_monitor_core
// Drives bytes and ticks into the frame parser and checks every reported
// event against a cycle-free prediction of the parser, level and alarm logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sensor_frame_parser_level_monitor_core;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] reading;
    logic [15:0] level;
    logic [6:0]  pct;
  } sensor_event_t;

  localparam sfplm_pkg::cfg_t CFG_AT_RESET = '{start_marker: 8'd170, accepted_type: 8'd1,
                                               vessel_depth: 16'd2000,
                                               byte_gap_limit: 16'd1000,
                                               silence_limit: 20'd30000};
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_REQUESTS = 175;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned SQUEEZE_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  sfplm_in_if  rx_chan ();
  sfplm_out_if event_chan ();

  sensor_frame_parser_level_monitor_core dut (
    .clk        (clk),
    .rst        (rst),
    .rx_chan    (rx_chan),
    .event_chan (event_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  request_t      pending_requests[$];
  sensor_event_t events_due[$];
  request_t      next_req;

  sfplm_pkg::cfg_t model_cfg;
  logic [7:0]  frame_buf[4];
  logic [2:0]  frame_pos;
  logic [15:0] gap_ticks;
  logic [19:0] quiet_ticks;
  logic        crc_bad_seen;
  logic        alarm_up;

  logic        idling_on;
  logic        squeeze;
  logic        squeeze_done;
  int unsigned send_gap;
  int unsigned hold_cycles;
  int unsigned errors;
  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned kind_count[4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void parse_request(request_t req);
    sensor_event_t ev;
    logic [7:0]    sum;
    int unsigned   lvl;
    ev = '0;
    if (req.op == sfplm_pkg::OP_TICK) begin
      if (gap_ticks != sfplm_pkg::GAP_MAX) gap_ticks++;
      if (frame_pos != 0 && gap_ticks > model_cfg.byte_gap_limit) frame_pos = 0;
      if (quiet_ticks != sfplm_pkg::SILENCE_MAX) quiet_ticks++;
      if (quiet_ticks > model_cfg.silence_limit && !alarm_up) begin
        alarm_up = 1'b1;
        ev.kind = crc_bad_seen ? sfplm_pkg::EV_BAD_PACKET : sfplm_pkg::EV_NO_SIGNAL;
        events_due.push_back(ev);
      end
      return;
    end
    gap_ticks = '0;
    if (frame_pos == 0 && req.data != model_cfg.start_marker) return;
    if (frame_pos < 4) begin
      frame_buf[frame_pos[1:0]] = req.data;
      frame_pos++;
      return;
    end
    frame_pos = 0;
    if (frame_buf[1] != model_cfg.accepted_type) return;
    sum = frame_buf[0] + frame_buf[1] + frame_buf[2] + frame_buf[3];
    if (sum != req.data) begin
      crc_bad_seen = 1'b1;
      ev.kind = sfplm_pkg::EV_CHECKSUM;
      events_due.push_back(ev);
      return;
    end
    quiet_ticks = '0;
    crc_bad_seen = 1'b0;
    alarm_up = 1'b0;
    ev.kind = sfplm_pkg::EV_GOOD;
    ev.reading = {frame_buf[2], frame_buf[3]};
    lvl = (ev.reading < model_cfg.vessel_depth) ? model_cfg.vessel_depth - ev.reading : 0;
    ev.level = lvl[15:0];
    if (model_cfg.vessel_depth != 0) begin
      lvl = (lvl * sfplm_pkg::PERCENT_SCALE) / model_cfg.vessel_depth;
      ev.pct = lvl[6:0];
    end
    events_due.push_back(ev);
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      rx_chan.valid <= 1'b0;
      rx_chan.opcode <= sfplm_pkg::OP_BYTE;
      rx_chan.rx_byte <= 8'd0;
      send_gap <= 0;
    end else if (!rx_chan.valid || rx_chan.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        rx_chan.valid <= 1'b0;
      end else if (idling_on && pending_requests.size() != 0 &&
                   $urandom_range(0, 11) == 0) begin
        send_gap <= $urandom_range(1, 19) - 1;
        rx_chan.valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        next_req = pending_requests.pop_front();
        rx_chan.valid <= 1'b1;
        rx_chan.opcode <= next_req.op;
        rx_chan.rx_byte <= next_req.data;
      end else begin
        rx_chan.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      event_chan.ready <= 1'b0;
      hold_cycles <= 0;
      squeeze_done <= 1'b0;
    end else if (squeeze && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_cycles <= SQUEEZE_CYCLES;
      event_chan.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      event_chan.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 11) == 0) begin
      hold_cycles <= $urandom_range(1, 19) - 1;
      event_chan.ready <= 1'b0;
    end else begin
      event_chan.ready <= 1'b1;
    end
  end

  // Monitor: predicts on accepted requests, checks accepted events.
  always @(posedge clk) begin
    sensor_event_t want;
    if (!rst) begin
      if (rx_chan.valid && rx_chan.ready) begin
        accepted_count++;
        parse_request('{op: rx_chan.opcode, data: rx_chan.rx_byte});
      end
      if (event_chan.valid && event_chan.ready) begin
        if (events_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected event, expected none, actual kind %0d", $time,
                   event_chan.event_kind);
        end else begin
          want = events_due.pop_front();
          kind_count[want.kind]++;
          check_field("event_kind", 16'(want.kind), 16'(event_chan.event_kind));
          check_field("echo_range", want.reading, event_chan.echo_range);
          check_field("fill_height", want.level, event_chan.fill_height);
          check_field("level_percent", 16'(want.pct), 16'(event_chan.level_percent));
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      sfplm_pkg::REG_START_MARKER:   model_cfg.start_marker = value[7:0];
      sfplm_pkg::REG_ACCEPTED_TYPE:  model_cfg.accepted_type = value[7:0];
      sfplm_pkg::REG_TANK_DEPTH:     model_cfg.vessel_depth = value[15:0];
      sfplm_pkg::REG_BYTE_GAP_LIMIT: model_cfg.byte_gap_limit = value[15:0];
      sfplm_pkg::REG_SILENCE_LIMIT:  model_cfg.silence_limit = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(sfplm_pkg::cfg_t c);
    write_reg(sfplm_pkg::REG_START_MARKER, 20'(c.start_marker));
    write_reg(sfplm_pkg::REG_ACCEPTED_TYPE, 20'(c.accepted_type));
    write_reg(sfplm_pkg::REG_TANK_DEPTH, 20'(c.vessel_depth));
    write_reg(sfplm_pkg::REG_BYTE_GAP_LIMIT, 20'(c.byte_gap_limit));
    write_reg(sfplm_pkg::REG_SILENCE_LIMIT, c.silence_limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_byte(logic [7:0] b);
    pending_requests.push_back('{op: sfplm_pkg::OP_BYTE, data: b});
    queued_count++;
  endtask

  task automatic queue_ticks(int unsigned n);
    repeat (n) begin
      pending_requests.push_back('{op: sfplm_pkg::OP_TICK, data: 8'($urandom)});
      queued_count++;
    end
  endtask

  // Five-byte frame; a nonzero skew corrupts the checksum byte.
  task automatic queue_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             logic [7:0] b3, logic [7:0] skew, bit loose);
    logic [7:0] sum;
    logic [7:0] body[4];
    sum = b0 + b1 + b2 + b3 + skew;
    body = '{b0, b1, b2, b3};
    foreach (body[i]) begin
      queue_byte(body[i]);
      if (loose && $urandom_range(0, 5) == 0) queue_ticks(1);
    end
    queue_byte(sum);
  endtask

  task automatic fill_random(int unsigned goal);
    int unsigned first;
    int unsigned pick;
    logic [15:0] span;
    logic [7:0]  skew;
    first = queued_count;
    while (queued_count - first < goal) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: span = model_cfg.vessel_depth + 16'($urandom_range(0, 2)) - 16'd1;
        1: span = 16'($urandom_range(0, 255));
        default: span = 16'($urandom);
      endcase
      skew = 8'($urandom_range(1, 255));
      if (pick < 55) begin
        queue_frame(model_cfg.start_marker, model_cfg.accepted_type, span[15:8], span[7:0],
                    8'd0, 1'b1);
      end else if (pick < 67) begin
        queue_frame(model_cfg.start_marker, model_cfg.accepted_type, span[15:8], span[7:0],
                    skew, 1'b1);
      end else if (pick < 75) begin
        queue_frame(model_cfg.start_marker, model_cfg.accepted_type ^ skew, span[15:8],
                    span[7:0], 8'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 83) begin
        queue_byte(model_cfg.start_marker);
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
        if (model_cfg.byte_gap_limit <= 40) begin
          queue_ticks(model_cfg.byte_gap_limit + $urandom_range(0, 2));
        end
      end else if (pick < 91) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else if (model_cfg.silence_limit <= 60) begin
        queue_ticks($urandom_range(1, model_cfg.silence_limit + 4));
      end else begin
        queue_ticks($urandom_range(1, 12));
      end
      queue_ticks($urandom_range(0, 3));
    end
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((pending_requests.size() != 0 || rx_chan.valid || events_due.size() != 0) &&
           waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sfplm_pkg::cfg_t setting;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = sfplm_pkg::REG_START_MARKER;
    cfg_data = '0;
    rx_chan.valid = 1'b0;
    rx_chan.opcode = sfplm_pkg::OP_BYTE;
    rx_chan.rx_byte = 8'd0;
    event_chan.ready = 1'b0;
    idling_on = 1'b0;
    squeeze = 1'b0;
    errors = 0;
    queued_count = 0;
    accepted_count = 0;
    kind_count = '{0, 0, 0, 0};
    model_cfg = CFG_AT_RESET;
    frame_buf = '{8'd0, 8'd0, 8'd0, 8'd0};
    frame_pos = '0;
    gap_ticks = '0;
    quiet_ticks = '0;
    crc_bad_seen = 1'b0;
    alarm_up = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: short limits so that timeouts and alarms come quickly.
    write_reg(sfplm_pkg::REG_START_MARKER, 20'hFF);
    write_reg(sfplm_pkg::REG_ACCEPTED_TYPE, 20'h00);
    write_reg(sfplm_pkg::REG_TANK_DEPTH, 20'd2000);
    write_reg(sfplm_pkg::REG_BYTE_GAP_LIMIT, 20'd2);
    write_reg(sfplm_pkg::REG_SILENCE_LIMIT, 20'd3);
    for (int i = sfplm_pkg::REG_SILENCE_LIMIT + 1; i < 8; i++) write_reg(3'(i), 20'hFFFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_frame(8'hFF, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
    queue_frame(8'hFF, 8'h00, 8'h12, 8'h34, 8'h5C, 1'b0);
    queue_ticks(4);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_ticks(3);
    queue_byte(8'h00);
    queue_frame(8'hFF, 8'h07, 8'h01, 8'h02, 8'd0, 1'b0);
    queue_frame(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'd0, 1'b0);
    queue_ticks(4);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      setting.start_marker = 8'($urandom);
      setting.accepted_type = 8'($urandom);
      setting.vessel_depth = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 300))
                                                         : 16'($urandom_range(1, 65535));
      setting.byte_gap_limit = 16'($urandom_range(1, 12));
      setting.silence_limit = 20'($urandom_range(1, 60));
      case (phase)
        0: setting = '{start_marker: 8'h00, accepted_type: 8'hFF, vessel_depth: 16'hFFFF,
                       byte_gap_limit: 16'hFFFF, silence_limit: 20'hFFFFF};
        1: setting = '{start_marker: 8'hFF, accepted_type: 8'h00, vessel_depth: 16'd1,
                       byte_gap_limit: 16'd1, silence_limit: 20'd1};
        3: setting.vessel_depth = 16'd0;
        default: ;
      endcase
      apply_setting(setting);
      idling_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        idling_on = 1'b1;
        squeeze = 1'b1;
      end
      fill_random(PHASE_REQUESTS);
      drain();
    end

    if (events_due.size() != 0) begin
      errors++;
      $display("%0t: %0d events still expected, actual none arrived", $time,
               events_due.size());
    end
    $display("Sent %0d bytes and ticks under %0d register settings.", accepted_count,
             PHASES + 1);
    $display("Checked %0d readings, %0d checksum errors, %0d no-signal and %0d %s",
             kind_count[sfplm_pkg::EV_GOOD], kind_count[sfplm_pkg::EV_CHECKSUM],
             kind_count[sfplm_pkg::EV_NO_SIGNAL], kind_count[sfplm_pkg::EV_BAD_PACKET],
             "bad-packet alarms.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/sfplm_pkg.sv
sv/sfplm_in_if.sv
sv/sfplm_out_if.sv
sv/sfplm_front.sv
sv/sfplm_queue.sv
sv/sfplm_back.sv
sv/sensor_frame_parser_level_monitor_core.sv
bench/tb_sensor_frame_parser_level_monitor_core.sv
